// ----- design/frr_pkg.sv -----
// Shared types, constants and arithmetic step functions for the Fresnel ray spawner.
// Depends on nothing; imported by fresnel_reflect_refract_rays.
`default_nettype none

package frr_pkg;

   localparam logic [13:0] ONE_Q12   = 14'd4096;
   localparam logic [13:0] MAT_RESET = 14'd6144;
   localparam logic [16:0] ONE_Q16   = 17'h10000;

   localparam logic RAY_REFL = 1'b0;
   localparam logic RAY_REFR = 1'b1;

   typedef struct packed {
      logic             vld;
      logic             none;
      logic             is_in;
      logic [7:0]       depth;
      logic [2:0][31:0] hit;
      logic [13:0]      m;
      logic [2:0][15:0] d;
      logic [2:0][16:0] n;
      logic [2:0][32:0] pdn;
      logic [2:0][31:0] pdd;
      logic [2:0][31:0] pnn;
      logic [34:0]      dot;
      logic [31:0]      vv;
      logic [31:0]      nn;
      logic [63:0]      pv;
      logic [63:0]      pr;
      logic [2:0][47:0] rl_rem;
      logic [2:0][16:0] rl_q;
      logic [2:0]       rl_neg;
      logic [31:0]      lv_v;
      logic [31:0]      lv_r;
      logic [31:0]      ln_v;
      logic [31:0]      ln_r;
      logic [29:0]      rd_rem;
      logic [15:0]      rd_q;
      logic [28:0]      et_rem;
      logic [16:0]      et_q;
      logic [2:0][15:0] refl;
      logic [17:0]      eta;
      logic [15:0]      r0;
      logic [19:0]      e2;
      logic [47:0]      cd_rem;
      logic [16:0]      cd_q;
      logic             cd_neg;
      logic [16:0]      ac;
      logic [16:0]      x;
      logic [16:0]      xp;
      logic [16:0]      csq;
      logic [34:0]      ec;
      logic [16:0]      sv;
      logic [18:0]      ecq;
      logic [21:0]      k;
      logic             tir;
      logic [33:0]      sk_v;
      logic [33:0]      sk_r;
      logic [16:0]      wprod;
      logic [16:0]      wr;
      logic [19:0]      b;
      logic [2:0][35:0] ra_rem;
      logic [2:0][35:0] rb_rem;
      logic [2:0][16:0] ra_q;
      logic [2:0][16:0] rb_q;
      logic [2:0]       ra_neg;
      logic [2:0]       rb_neg;
      logic [2:0][15:0] refr;
   } pipe_type;

   typedef struct packed {
      logic             vld;
      logic             tir;
      logic             is_in;
      logic [7:0]       depth;
      logic [2:0][31:0] hit;
      logic [16:0]      wr;
      logic [2:0][15:0] refl;
      logic [2:0][15:0] refr;
   } emit_type;

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [64:0] udiv_step(input logic [63:0] rem, input logic [63:0] dsh);
      logic [64:0] res;
      if (rem >= dsh) begin
         res = {1'b1, rem - dsh};
      end else begin
         res = {1'b0, rem};
      end
      return res;
   endfunction

   // one digit of the integer square root: {new value, new root}
   function automatic logic [127:0] isqrt_step(input logic [63:0] v, input logic [63:0] r,
                                               input logic [63:0] b);
      logic [63:0] rb;
      logic [127:0] res;
      rb = r + b;
      if (v >= rb) begin
         res = {v - rb, (r >> 1) + b};
      end else begin
         res = {v, r >> 1};
      end
      return res;
   endfunction

   function automatic logic [15:0] sat16(input logic signed [23:0] v);
      logic [15:0] res;
      if (v > 24'sd32767) begin
         res = 16'h7fff;
      end else if (v < -24'sd32768) begin
         res = 16'h8000;
      end else begin
         res = v[15:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- design/fresnel_reflect_refract_rays.sv -----
// Fresnel reflection/refraction ray spawner: pipeline, output beat register, config register.
// Depends on frr_pkg.
//
// One hit enters per beat on req_; each hit with nonzero depth yields a reflected ray beat
// (weight R, Schlick) and, unless total internal reflection, a refracted ray beat (weight
// 1-R), the last one flagged by rsp_tlast and the kind in rsp_tuser. The datapath is a
// 96-stage pipeline (square roots and divisions one digit per stage) that takes a hit every
// cycle except while the output register holds rays whose last beat is not yet taken; the
// output register sends the rays of one hit one beat per cycle while rsp_tready is high.
// The user must write material_index through csr_wr_en/csr_wr_data only while no hit is
// in flight; the block itself does not enforce this.
`default_nettype none

module fresnel_reflect_refract_rays
   import frr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [13:0]  csr_wr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, hit_x, hit_y, hit_z, inside_flag, depth_left
   input  wire logic [207:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // weight, out_dir_x, out_dir_y, out_dir_z, origin_x, origin_y, origin_z, out_inside,
   // out_depth
   output logic [175:0]      rsp_tdata,
   // ray_kind
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   localparam int S_MUL1  = 1;
   localparam int S_SUM   = 2;
   localparam int S_MUL2  = 3;
   localparam int S_A     = 4;
   localparam int S_REFL  = 21;
   localparam int S_CINIT = 36;
   localparam int S_C     = 37;
   localparam int S_CEND  = 54;
   localparam int S_P1    = 55;
   localparam int S_P2    = 56;
   localparam int S_P3    = 57;
   localparam int S_P4    = 58;
   localparam int S_K     = 59;
   localparam int S_W1    = 59;
   localparam int S_W2    = 60;
   localparam int S_B     = 76;
   localparam int S_RM    = 77;
   localparam int S_R     = 78;
   localparam int S_RFIN  = 95;
   localparam int NS      = 96;

   function automatic pipe_type stage_fn(input pipe_type p, input int s);
      pipe_type o;
      logic [64:0] dq;
      logic [127:0] sqr;
      logic signed [32:0] m33;
      logic signed [34:0] s35;
      logic signed [19:0] s20;
      logic signed [18:0] qa;
      logic signed [18:0] qb;
      logic signed [18:0] e19;
      logic signed [23:0] w24;
      logic [34:0] a35;
      logic [31:0] adot;
      logic [16:0] t17;
      logic [15:0] an;
      logic [15:0] ad;
      logic [14:0] msum;
      logic [63:0] u64;
      logic [48:0] u49;
      logic [37:0] u38;
      logic [35:0] u36;
      logic [33:0] u34;
      logic [31:0] u32;
      logic [17:0] u18;
      logic [19:0] bmag;
      int j;
      o    = p;
      msum = {1'b0, p.m} + {1'b0, ONE_Q12};
      a35  = p.dot[34] ? (~p.dot + 35'd1) : p.dot;
      adot = a35[31:0];
      bmag = p.b[19] ? (~p.b + 20'd1) : p.b;
      j    = 0;

      if (s == S_MUL1) begin
         for (int i = 0; i < 3; i++) begin
            m33 = $signed(p.d[i]) * $signed(p.n[i]);
            o.pdn[i] = m33;
            m33 = $signed(p.d[i]) * $signed(p.d[i]);
            o.pdd[i] = m33[31:0];
            m33 = $signed(p.n[i]) * $signed(p.n[i]);
            o.pnn[i] = m33[31:0];
         end
      end

      if (s == S_SUM) begin
         s35 = $signed(p.pdn[0]) + $signed(p.pdn[1]) + $signed(p.pdn[2]);
         o.dot = s35;
         o.vv  = p.pdd[0] + p.pdd[1] + p.pdd[2];
         o.nn  = p.pnn[0] + p.pnn[1] + p.pnn[2];
      end

      if (s == S_MUL2) begin
         u64  = p.vv * p.nn;
         o.pv = u64;
         o.pr = '0;
         for (int i = 0; i < 3; i++) begin
            t17 = p.n[i][16] ? (~p.n[i] + 17'd1) : p.n[i];
            an  = t17[15:0];
            u49 = {adot, 1'b0} * an;
            o.rl_rem[i] = u49[47:0];
            o.rl_neg[i] = p.dot[34] ^ p.n[i][16];
            o.rl_q[i]   = '0;
         end
         o.lv_v   = p.vv;
         o.lv_r   = '0;
         o.ln_v   = p.nn;
         o.ln_r   = '0;
         o.rd_rem = {p.m - ONE_Q12, 16'd0};
         o.rd_q   = '0;
         o.et_rem = 29'h1000_0000;
         o.et_q   = '0;
      end

      if (s >= S_A && s < S_A + 32) begin
         j   = s - S_A;
         sqr = isqrt_step(p.pv, p.pr, 64'd1 << (2 * (31 - j)));
         o.pv = sqr[127:64];
         o.pr = sqr[63:0];
         if (j < 17) begin
            for (int i = 0; i < 3; i++) begin
               dq = udiv_step({16'd0, p.rl_rem[i]}, {32'd0, p.nn} << (16 - j));
               o.rl_rem[i]         = dq[47:0];
               o.rl_q[i][16 - j]   = dq[64];
            end
            dq = udiv_step({35'd0, p.et_rem}, {50'd0, p.m} << (16 - j));
            o.et_rem       = dq[28:0];
            o.et_q[16 - j] = dq[64];
         end
         if (j < 16) begin
            sqr = isqrt_step({32'd0, p.lv_v}, {32'd0, p.lv_r}, 64'd1 << (2 * (15 - j)));
            o.lv_v = sqr[95:64];
            o.lv_r = sqr[31:0];
            sqr = isqrt_step({32'd0, p.ln_v}, {32'd0, p.ln_r}, 64'd1 << (2 * (15 - j)));
            o.ln_v = sqr[95:64];
            o.ln_r = sqr[31:0];
            dq = udiv_step({34'd0, p.rd_rem}, {49'd0, msum} << (15 - j));
            o.rd_rem       = dq[29:0];
            o.rd_q[15 - j] = dq[64];
         end
      end

      if (s == S_REFL) begin
         for (int i = 0; i < 3; i++) begin
            qa  = p.rl_neg[i] ? -$signed({2'b0, p.rl_q[i]}) : $signed({2'b0, p.rl_q[i]});
            w24 = $signed(p.d[i]) - qa;
            o.refl[i] = (p.nn == '0) ? p.d[i] : sat16(w24);
         end
         o.eta = p.is_in ? {p.m, 4'd0} : {1'b0, p.et_q};
         u32   = p.rd_q * p.rd_q;
         o.r0  = u32[31:16];
         u36   = o.eta * o.eta;
         o.e2  = u36[35:16];
      end

      if (s == S_CINIT) begin
         o.cd_rem = {adot, 16'd0};
         o.cd_neg = p.dot[34];
         o.cd_q   = '0;
      end

      if (s >= S_C && s < S_C + 17) begin
         j  = s - S_C;
         dq = udiv_step({16'd0, p.cd_rem}, {32'd0, p.pr[31:0]} << (16 - j));
         o.cd_rem       = dq[47:0];
         o.cd_q[16 - j] = dq[64];
      end

      if (s == S_CEND) begin
         o.ac = (p.pr == '0) ? '0 : p.cd_q;
         o.x  = ONE_Q16 - o.ac;
      end

      if (s == S_P1) begin
         u34   = p.x * p.x;
         o.xp  = u34[32:16];
         u34   = p.ac * p.ac;
         o.csq = u34[32:16];
         o.ec  = p.eta * p.ac;
      end

      if (s == S_P2) begin
         u34   = p.xp * p.x;
         o.xp  = u34[32:16];
         o.sv  = ONE_Q16 - p.csq;
         e19   = $signed({1'b0, p.ec[33:16]});
         o.ecq = p.cd_neg ? -e19 : e19;
      end

      if (s == S_P3) begin
         u34  = p.xp * p.x;
         o.xp = u34[32:16];
         u38  = p.e2 * p.sv;
         o.k  = 22'h010000 - {2'b0, u38[35:16]};
      end

      if (s == S_P4) begin
         u34   = p.xp * p.x;
         o.xp  = u34[32:16];
         o.tir = p.is_in && (p.m > ONE_Q12) &&
                 ((!p.dot[34] && (p.dot != '0)) || p.k[21]);
         o.sk_v = p.k[21] ? '0 : {1'b0, p.k[16:0], 16'd0};
         o.sk_r = '0;
      end

      if (s >= S_K && s < S_K + 17) begin
         j   = s - S_K;
         sqr = isqrt_step({30'd0, p.sk_v}, {30'd0, p.sk_r}, 64'd1 << (2 * (16 - j)));
         o.sk_v = sqr[97:64];
         o.sk_r = sqr[33:0];
      end

      if (s == S_W1) begin
         u34     = (ONE_Q16 - {1'b0, p.r0}) * p.xp;
         o.wprod = u34[32:16];
      end

      if (s == S_W2) begin
         u18  = {2'b0, p.r0} + {1'b0, p.wprod};
         o.wr = (u18 > {1'b0, ONE_Q16}) ? ONE_Q16 : u18[16:0];
      end

      if (s == S_B) begin
         s20 = $signed(p.ecq) + $signed({3'b0, p.sk_r[16:0]});
         o.b = s20;
      end

      if (s == S_RM) begin
         for (int i = 0; i < 3; i++) begin
            t17 = p.n[i][16] ? (~p.n[i] + 17'd1) : p.n[i];
            an  = t17[15:0];
            ad  = p.d[i][15] ? (~p.d[i] + 16'd1) : p.d[i];
            u36 = p.eta * ad;
            o.ra_rem[i] = u36;
            o.ra_neg[i] = p.d[i][15];
            o.ra_q[i]   = '0;
            u36 = bmag * an;
            o.rb_rem[i] = u36;
            o.rb_neg[i] = p.b[19] ^ p.n[i][16];
            o.rb_q[i]   = '0;
         end
      end

      if (s >= S_R && s < S_R + 17) begin
         j = s - S_R;
         for (int i = 0; i < 3; i++) begin
            dq = udiv_step({28'd0, p.ra_rem[i]}, {46'd0, p.lv_r[15:0], 2'b0} << (16 - j));
            o.ra_rem[i]       = dq[35:0];
            o.ra_q[i][16 - j] = dq[64];
            dq = udiv_step({28'd0, p.rb_rem[i]}, {46'd0, p.ln_r[15:0], 2'b0} << (16 - j));
            o.rb_rem[i]       = dq[35:0];
            o.rb_q[i][16 - j] = dq[64];
         end
      end

      if (s == S_RFIN) begin
         for (int i = 0; i < 3; i++) begin
            qa  = p.ra_neg[i] ? -$signed({2'b0, p.ra_q[i]}) : $signed({2'b0, p.ra_q[i]});
            qb  = p.rb_neg[i] ? -$signed({2'b0, p.rb_q[i]}) : $signed({2'b0, p.rb_q[i]});
            w24 = qa - qb;
            o.refr[i] = (p.lv_r == '0 || p.ln_r == '0) ? '0 : sat16(w24);
         end
      end

      return o;
   endfunction

   logic [13:0] mat_ff;
   logic [13:0] mat_in;
   pipe_type    pipe_ff [NS];
   pipe_type    pipe_in [NS];
   emit_type    emit_ff;
   emit_type    emit_in;
   logic        phase_ff;
   logic        phase_in;
   logic        adv;
   logic        beat_done;
   pipe_type    ld;
   logic [16:0] weight;
   logic [2:0][15:0] out_dir;

   always_comb begin
      mat_in = csr_wr_en ? csr_wr_data : mat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= MAT_RESET;
      end else begin
         mat_ff <= mat_in;
      end
   end

   always_comb begin
      ld        = '0;
      ld.vld    = req_tvalid;
      ld.is_in  = req_tdata[192];
      ld.depth  = req_tdata[200:193];
      ld.none   = (req_tdata[200:193] == 8'd0);
      ld.m      = (mat_ff < ONE_Q12) ? ONE_Q12 : mat_ff;
      for (int i = 0; i < 3; i++) begin
         ld.d[i]   = req_tdata[16 * i +: 16];
         ld.n[i]   = req_tdata[192] ? (~{req_tdata[48 + 16 * i + 15], req_tdata[48 + 16 * i +: 16]}
                                       + 17'd1)
                                    : {req_tdata[48 + 16 * i + 15], req_tdata[48 + 16 * i +: 16]};
         ld.hit[i] = req_tdata[96 + 32 * i +: 32];
      end
   end

   assign pipe_in[0] = ld;

   for (genvar g = 1; g < NS; g++) begin : g_stage
      assign pipe_in[g] = stage_fn(pipe_ff[g - 1], g);
   end

   assign beat_done  = rsp_tvalid && rsp_tready;
   assign adv        = !emit_ff.vld || (beat_done && rsp_tlast);
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            pipe_ff[s].vld <= 1'b0;
         end
      end else if (adv) begin
         for (int s = 0; s < NS; s++) begin
            pipe_ff[s] <= pipe_in[s];
         end
      end
   end

   always_comb begin
      emit_in  = emit_ff;
      phase_in = phase_ff;
      if (adv) begin
         emit_in.vld    = pipe_ff[NS - 1].vld && !pipe_ff[NS - 1].none;
         emit_in.tir    = pipe_ff[NS - 1].tir;
         emit_in.is_in  = pipe_ff[NS - 1].is_in;
         emit_in.depth  = pipe_ff[NS - 1].depth;
         emit_in.hit    = pipe_ff[NS - 1].hit;
         emit_in.wr     = pipe_ff[NS - 1].wr;
         emit_in.refl   = pipe_ff[NS - 1].refl;
         emit_in.refr   = pipe_ff[NS - 1].refr;
         phase_in       = RAY_REFL;
      end else if (beat_done) begin
         phase_in = RAY_REFR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff.vld <= 1'b0;
         phase_ff    <= RAY_REFL;
      end else begin
         emit_ff  <= emit_in;
         phase_ff <= phase_in;
      end
   end

   assign weight     = (phase_ff == RAY_REFR) ? (ONE_Q16 - emit_ff.wr) : emit_ff.wr;
   assign out_dir    = (phase_ff == RAY_REFR) ? emit_ff.refr : emit_ff.refl;
   assign rsp_tvalid = emit_ff.vld;
   assign rsp_tuser  = phase_ff;
   assign rsp_tlast  = emit_ff.tir || (phase_ff == RAY_REFR);
   assign rsp_tdata  = {6'd0,
                        emit_ff.depth - 8'd1,
                        emit_ff.is_in ^ (phase_ff == RAY_REFR),
                        emit_ff.hit,
                        out_dir,
                        weight};

`ifndef SYNTH
   a_refr_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == RAY_REFR |-> rsp_tlast)
      else $error("refracted beat not marked last");

   a_refl_then_refr: assert property (@(posedge clock) disable iff (reset)
      beat_done && !rsp_tlast |=> rsp_tvalid && rsp_tuser == RAY_REFR)
      else $error("reflected beat not followed by refracted beat");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      emit_ff.vld |-> emit_ff.wr <= ONE_Q16)
      else $error("reflection weight above one");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      emit_ff.vld && !beat_done |=> emit_ff.vld && $stable(phase_ff))
      else $error("pending ray lost or advanced while stalled");
`endif

endmodule

`default_nettype wire
